// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property macros for the smoother RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define GNTS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define GNTS_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define GNTS_ASSERT(name, clk, rst, prop, msg)
`define GNTS_NEVER(name, clk, rst, expr, msg)
`endif

`endif

// File: src/gnts_pkg.sv
// ----------------------------------------------------------------------------
// gnts_pkg
// Types, sizes and codes shared by the grid threshold smoother modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gnts_pkg;

  // Stored grid size.
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // Index and count widths derived from the stored size.
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int COL_CW = $clog2(MAX_COLS + 1);
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SOLID_LIMIT = 2'd2;
  localparam logic [1:0] CFG_PASS_COUNT  = 2'd3;

  // Configuration reset values.
  localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;
  localparam logic [3:0] SOLID_LIMIT_RST = 4'd4;
  localparam logic [3:0] PASS_COUNT_RST  = 4'd5;

  // One stored row of cells.
  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] ack_kind;
    logic       cell_out;
  } out_item_t;

  typedef struct packed {
    logic [6:0] grid_width;
    logic [6:0] grid_height;
    logic [3:0] solid_limit;
    logic [3:0] pass_count;
  } cfg_t;

  // Finished result offered by the engine.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

// File: src/grid_neighbour_threshold_smoother.sv
// A write or read fetches its row, writes or reads the cell and then offers its result; the next
// item is taken only after that result has gone to the output register. An unknown request or a
// run of zero passes goes straight to offering its result; a run of passes sweeps one grid row per
// cycle per pass over the rows in use and then offers its result.
// Reset clears the handshake state and sets the configuration to its defaults; the grid
// contents are undefined until written and no clearing sweep runs.
// ----------------------------------------------------------------------------
// grid_neighbour_threshold_smoother
// Binary grid smoother: cell writes and reads plus threshold smoothing passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbour_threshold_smoother import gnts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    eng_idle;
  logic    in_fire;
  logic    res_take;

  assign in_stall  = !eng_idle;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= GRID_WIDTH_RST;
      cfg.grid_height <= GRID_HEIGHT_RST;
      cfg.solid_limit <= SOLID_LIMIT_RST;
      cfg.pass_count  <= PASS_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  cfg.grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: cfg.grid_height <= cfg_data;
        CFG_SOLID_LIMIT: cfg.solid_limit <= cfg_data[3:0];
        CFG_PASS_COUNT:  cfg.pass_count  <= cfg_data[3:0];
      endcase
    end
  end

  gnts_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_item  (in_item),
    .cfg      (cfg),
    .idle     (eng_idle),
    .res      (res),
    .res_take (res_take)
  );

  // Output register; a new result loads when the slot is empty or being drained.
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res.item;
    end
  end

endmodule

`default_nettype wire

// File: src/gnts_row_rule.sv
// ----------------------------------------------------------------------------
// gnts_row_rule
// Computes one smoothed row from the old rows above, at and below it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnts_row_rule import gnts_pkg::*; (
  input  row_t              above,
  input  row_t              mid,
  input  row_t              below,
  input  logic [COL_CW-1:0] width_eff,
  input  logic [3:0]        solid_limit,
  output row_t              next_row
);

  // The first and last stored columns are never interior.
  assign next_row[0]          = mid[0];
  assign next_row[MAX_COLS-1] = mid[MAX_COLS-1];

  // Each interior column counts its eight neighbors and compares.
  for (genvar x = 1; x < MAX_COLS - 1; x++) begin : g_col
    logic [3:0] cnt;
    assign cnt = 4'(above[x-1]) + 4'(above[x]) + 4'(above[x+1])
               + 4'(mid[x-1]) + 4'(mid[x+1])
               + 4'(below[x-1]) + 4'(below[x]) + 4'(below[x+1]);
    assign next_row[x] = (32'(width_eff) > x + 1) ? (cnt > solid_limit) : mid[x];
  end

endmodule

`default_nettype wire

// File: src/gnts_engine.sv
// ----------------------------------------------------------------------------
// gnts_engine
// Row-wide grid memory with the request sequencer and smoothing pass sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gnts_engine import gnts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     idle,
  output result_t  res,
  input  logic     res_take
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_PASS   = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  state_t state;

  // Grid storage, one row per entry, and its registered read data.
  row_t mem [MAX_ROWS];
  row_t mem_q;

  logic              rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic              mem_we;
  logic [ROW_AW-1:0] wr_addr;
  row_t              wr_data;

  // Request being served.
  in_item_t req;
  logic     inside_q;
  logic     hold_cell;

  // Pass sweep state.
  logic [ROW_CW-1:0] iss_row;
  logic [ROW_AW-1:0] pass_row;
  logic              pass_dv;
  logic [3:0]        passes_left;
  row_t              win_prev;
  row_t              win_cur;
  row_t              rule_row;

  logic              in_inside;
  logic              pass_rd;
  logic [COL_CW-1:0] width_eff;
  logic [ROW_CW-1:0] height_eff;
  logic [COL_AW-1:0] col_idx;

  // Region limited to the stored size.
  assign width_eff  = (32'(cfg.grid_width) > MAX_COLS) ? COL_CW'(MAX_COLS)
                                                       : COL_CW'(cfg.grid_width);
  assign height_eff = (32'(cfg.grid_height) > MAX_ROWS) ? ROW_CW'(MAX_ROWS)
                                                        : ROW_CW'(cfg.grid_height);

  assign in_inside = (32'(in_item.col) < MAX_COLS) && (32'(in_item.row) < MAX_ROWS);
  assign col_idx   = COL_AW'(req.col);
  assign pass_rd   = (state == S_PASS) && (iss_row < height_eff);

  // New row from the two held rows and the row just read.
  gnts_row_rule u_rule (
    .above       (win_prev),
    .mid         (win_cur),
    .below       (mem_q),
    .width_eff   (width_eff),
    .solid_limit (cfg.solid_limit),
    .next_row    (rule_row)
  );

  // Read port: a cell access reads its row at acceptance, a pass reads row by row.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ROW_AW'(in_item.row);
    if (state == S_IDLE) begin
      rd_en = in_fire && in_inside &&
              (in_item.req_type == REQ_WRITE || in_item.req_type == REQ_READ);
    end else if (pass_rd) begin
      rd_en   = 1'b1;
      rd_addr = ROW_AW'(iss_row);
    end
  end

  // Write port: cell writes modify the fetched row, a pass writes back interior rows.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = ROW_AW'(req.row);
    wr_data = mem_q;
    if (state == S_ACCESS) begin
      mem_we           = (req.req_type == REQ_WRITE) && inside_q;
      wr_data[col_idx] = req.cell_in;
    end else if (pass_dv && pass_row > ROW_AW'(1)) begin
      mem_we  = 1'b1;
      wr_addr = pass_row - ROW_AW'(1);
      wr_data = rule_row;
    end
  end

  // Memory array with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Row window holds the old values of the two rows above the incoming one.
  always_ff @(posedge clk) begin
    if (pass_dv) begin
      win_prev <= win_cur;
      win_cur  <= mem_q;
    end
    if (pass_rd) begin
      pass_row <= ROW_AW'(iss_row);
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pass_dv     <= 1'b0;
      iss_row     <= '0;
      passes_left <= '0;
    end else begin
      pass_dv <= pass_rd;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req       <= in_item;
            inside_q  <= in_inside;
            hold_cell <= 1'b0;
            case (in_item.req_type) inside
              REQ_WRITE, REQ_READ: begin
                state <= S_ACCESS;
              end
              REQ_RUN: begin
                iss_row     <= '0;
                passes_left <= cfg.pass_count;
                state       <= (cfg.pass_count != 4'd0) ? S_PASS : S_HOLD;
              end
              default: begin
                state <= S_HOLD;
              end
            endcase
          end
        end
        S_ACCESS: begin
          hold_cell <= (req.req_type == REQ_READ) && inside_q && mem_q[col_idx];
          state     <= S_HOLD;
        end
        S_PASS: begin
          if (pass_rd) begin
            iss_row <= iss_row + ROW_CW'(1);
          end else begin
            // Last row of this pass is written back in this cycle.
            iss_row     <= '0;
            passes_left <= passes_left - 4'd1;
            if (passes_left == 4'd1) begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle               = (state == S_IDLE);
  assign res.valid          = (state == S_HOLD);
  assign res.item.ack_kind  = req.req_type;
  assign res.item.cell_out  = hold_cell;

  // Checks on the sequencer and memory traffic.
  `GNTS_ASSERT(a_we_state, clk, rst, mem_we |-> (state == S_PASS || state == S_ACCESS), "memory write outside an access or pass")
  `GNTS_ASSERT(a_leave_idle, clk, rst, in_fire |=> (state != S_IDLE), "accepted item did not start work")
  `GNTS_ASSERT(a_pass_left, clk, rst, (state == S_PASS) |-> (passes_left != 4'd0), "pass sweep with no pass left")
  `GNTS_NEVER(a_dv_idle, clk, rst, pass_dv && (state == S_IDLE), "row data arriving after the run ended")

endmodule

`default_nettype wire

// File: tb/grid_neighbour_threshold_smoother_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbour_threshold_smoother_tb
// Self-checking bench for the grid smoother. Cell writes, reads, smoothing runs
// and unused request codes are driven in bursts against a stalling receiver.
// A scoreboard keeps its own copy of the grid and the registers and checks
// every result in order. Registers change only between phases.
// ----------------------------------------------------------------------------

import gnts_pkg::*;

// Keeps the expected grid and registers, and the queue of pending answers.
class smoother_scoreboard;
  row_t cells [MAX_ROWS];
  int unsigned grid_width;
  int unsigned grid_height;
  int unsigned solid_limit;
  int unsigned pass_count;
  out_item_t answers [$];
  int errors;

  function new();
    grid_width = GRID_WIDTH_RST;
    grid_height = GRID_HEIGHT_RST;
    solid_limit = SOLID_LIMIT_RST;
    pass_count = PASS_COUNT_RST;
    errors = 0;
    foreach (cells[r]) cells[r] = '0;
  endfunction

  // Registers hold only as many bits as they are wide.
  function void set_reg(logic [1:0] index, logic [6:0] data);
    case (index)
      CFG_GRID_WIDTH: grid_width = data;
      CFG_GRID_HEIGHT: grid_height = data;
      CFG_SOLID_LIMIT: solid_limit = data[3:0];
      CFG_PASS_COUNT: pass_count = data[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return answers.size();
  endfunction

  // Apply one accepted request to the grid and queue the answer it earns.
  function void note_input(in_item_t req);
    out_item_t ans;
    row_t nxt [MAX_ROWS];
    int w;
    int h;
    int n;
    ans.ack_kind = req.req_type;
    ans.cell_out = 1'b0;
    case (req.req_type)
      REQ_WRITE: cells[req.row][req.col] = req.cell_in;
      REQ_READ: ans.cell_out = cells[req.row][req.col];
      REQ_RUN: begin
        // The region is clipped to the stored grid; its border never changes.
        w = (grid_width > MAX_COLS) ? MAX_COLS : int'(grid_width);
        h = (grid_height > MAX_ROWS) ? MAX_ROWS : int'(grid_height);
        for (int p = 0; p < int'(pass_count); p++) begin
          nxt = cells;
          for (int y = 1; y + 1 < h; y++) begin
            for (int x = 1; x + 1 < w; x++) begin
              n = 0;
              for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                  if (dy != 0 || dx != 0) n += int'(cells[y + dy][x + dx]);
                end
              end
              nxt[y][x] = (n > int'(solid_limit));
            end
          end
          cells = nxt;
        end
      end
      default: ;
    endcase
    answers.push_back(ans);
  endfunction

  // Compare one accepted result with the oldest pending answer.
  function void check_result(out_item_t got);
    out_item_t want;
    if (answers.size() == 0) begin
      $error("result with no request outstanding: ack_kind %0d cell_out %0d",
             got.ack_kind, got.cell_out);
      errors++;
      return;
    end
    want = answers.pop_front();
    if (got.ack_kind !== want.ack_kind) begin
      $error("ack_kind mismatch: expected %0d, actual %0d", want.ack_kind, got.ack_kind);
      errors++;
    end
    if (got.cell_out !== want.cell_out) begin
      $error("cell_out mismatch: expected %0d, actual %0d", want.cell_out, got.cell_out);
      errors++;
    end
  endfunction
endclass

module grid_neighbour_threshold_smoother_tb;

  // The block answers code three like any other request.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int FIXED_PHASES = 10;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 32;
  // Loaded cells: the first rows, the first columns and a square block at the origin.
  localparam int FILL_EDGE = 3;
  localparam int FILL_BLOCK = 16;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  smoother_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  // Receiver stall pattern state.
  int seg_left = 0;
  int seg_mode = 0;
  int seg_period = 2;
  int seg_duty = 1;
  int seg_cnt = 0;

  // Register settings per phase: width, height, threshold, passes. Every region
  // lies on loaded cells.
  int fixed_cfg [FIXED_PHASES][4] = '{
    '{127, 3, 4, 2},
    '{3, 3, 0, 1},
    '{3, 127, 8, 15},
    '{2, 9, 2, 3},
    '{9, 1, 2, 3},
    '{0, 0, 3, 2},
    '{16, 12, 15, 4},
    '{12, 16, 9, 3},
    '{16, 16, 5, 0},
    '{64, 3, 3, 7}
  };

  grid_neighbour_threshold_smoother u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls in segments: none, a fixed duty pattern, or coin flips.
  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_left = $urandom_range(20, 200);
      seg_mode = $urandom_range(0, 2);
      seg_period = $urandom_range(2, 8);
      seg_duty = $urandom_range(1, seg_period - 1);
      seg_cnt = 0;
    end
    seg_left--;
    seg_cnt = (seg_cnt + 1) % seg_period;
    case (seg_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= (seg_cnt < seg_duty);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Check every result the moment it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Stop the run when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Cells written by the opening load.
  function automatic bit loaded(int col, int row);
    return (row < FILL_EDGE) || (col < FILL_EDGE) || (row < FILL_BLOCK && col < FILL_BLOCK);
  endfunction

  function automatic in_item_t make_req(logic [1:0] kind, int col, int row, int val);
    in_item_t req;
    req.req_type = kind;
    req.col = 6'(col);
    req.row = 6'(row);
    req.cell_in = 1'(val);
    return req;
  endfunction

  // Offer one item; the sender sometimes pauses between bursts of random length.
  task automatic send_item(in_item_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_item <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(req);
    @(negedge clk);
  endtask

  // Hold one register write until it is taken; the caller drops valid.
  task automatic write_reg(logic [1:0] index, logic [6:0] data);
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(index, data);
    @(negedge clk);
  endtask

  // Wait for every pending answer, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Set the registers, then mix writes, reads, runs and unused codes over the region.
  task automatic run_phase(int width, int height, int thr, int passes, int count);
    int w_eff;
    int h_eff;
    int roll;
    int c;
    int r;
    in_item_t req;
    write_reg(CFG_GRID_WIDTH, 7'(width));
    write_reg(CFG_GRID_HEIGHT, 7'(height));
    write_reg(CFG_SOLID_LIMIT, 7'(thr));
    write_reg(CFG_PASS_COUNT, 7'(passes));
    cfg_valid <= 1'b0;
    w_eff = (width == 0 || width > MAX_COLS) ? MAX_COLS : width;
    h_eff = (height == 0 || height > MAX_ROWS) ? MAX_ROWS : height;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      req.cell_in = 1'($urandom_range(0, 1));
      // Most accesses land inside the region so that runs are observed; all of
      // them stay on loaded cells.
      do begin
        c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_COLS - 1)
                                        : $urandom_range(0, w_eff - 1);
        r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_ROWS - 1)
                                        : $urandom_range(0, h_eff - 1);
      end while (!loaded(c, r));
      req.col = 6'(c);
      req.row = 6'(r);
      if (roll < 50) req.req_type = REQ_WRITE;
      else if (roll < 88) req.req_type = REQ_READ;
      else if (roll < 96) req.req_type = REQ_RUN;
      else req.req_type = REQ_UNUSED;
      send_item(req);
    end
    drain();
  endtask

  initial begin
    int shape;
    int width;
    int height;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Only the height leaves its reset value before the first run.
    write_reg(CFG_GRID_HEIGHT, 7'd3);
    cfg_valid <= 1'b0;

    // Load the first rows, the first columns and the block at the origin with
    // noise so that every later read or run touches written cells only.
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        if (loaded(c, r)) send_item(make_req(REQ_WRITE, c, r, $urandom_range(0, 1)));
      end
    end

    // Corners, unused code with all fields at both extremes, a run with the
    // reset width, threshold and pass count, and read-back.
    send_item(make_req(REQ_WRITE, 0, 0, 1));
    send_item(make_req(REQ_WRITE, 63, 63, 1));
    send_item(make_req(REQ_WRITE, 63, 0, 0));
    send_item(make_req(REQ_WRITE, 0, 63, 1));
    send_item(make_req(REQ_READ, 0, 0, 0));
    send_item(make_req(REQ_READ, 63, 63, 1));
    send_item(make_req(REQ_READ, 63, 0, 1));
    send_item(make_req(REQ_READ, 0, 63, 0));
    send_item(make_req(REQ_UNUSED, 63, 63, 1));
    send_item(make_req(REQ_UNUSED, 0, 0, 0));
    send_item(make_req(REQ_RUN, 63, 63, 1));
    send_item(make_req(REQ_READ, 0, 0, 0));
    send_item(make_req(REQ_READ, 63, 63, 0));
    send_item(make_req(REQ_READ, 1, 1, 0));
    send_item(make_req(REQ_READ, 32, 1, 0));
    send_item(make_req(REQ_READ, 62, 1, 0));
    send_item(make_req(REQ_WRITE, 31, 31, 0));
    send_item(make_req(REQ_READ, 31, 31, 1));
    drain();

    for (int p = 0; p < FIXED_PHASES; p++) begin
      run_phase(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2], fixed_cfg[p][3],
                ITEMS_PER_PHASE);
    end

    // Random settings: a small region or a strip along the loaded rows or columns,
    // each half the time, and mostly few passes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      shape = $urandom_range(0, 3);
      if (shape == 0) begin
        width = $urandom_range(3, 127);
        height = FILL_EDGE;
      end else if (shape == 1) begin
        width = FILL_EDGE;
        height = $urandom_range(3, 127);
      end else begin
        width = $urandom_range(3, FILL_BLOCK);
        height = $urandom_range(3, FILL_BLOCK);
      end
      run_phase(width, height, $urandom_range(0, 8),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5),
                ITEMS_PER_PHASE);
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
